// ===== src/trimmed_mean_median_filter_unit_assert.svh =====
// Assertion macros for the checker file.
`ifndef TRIMMED_MEAN_MEDIAN_FILTER_UNIT_ASSERT_SVH
`define TRIMMED_MEAN_MEDIAN_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TMF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tmf check failed");

// Next-cycle implication, disabled during reset.
`define TMF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tmf check failed");

`endif

// ===== src/tmf_pkg.sv =====
// Shared constants and types of the trimmed mean / median filter.
package tmf_pkg;
   localparam int MAX_SAMPLES   = 32;
   localparam int SAMPLE_BITS   = 16;
   localparam int FRACTION_BITS = 4;
   localparam int LIMIT_BITS    = 8;
   localparam int VALUE_BITS    = 20;
   localparam int INDEX_BITS    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int COUNT_BITS    = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
   localparam int DVD_BITS      = SUM_BITS + FRACTION_BITS;
   localparam int STEP_BITS     = $clog2(DVD_BITS + 1);
   localparam int REQ_BYTES     = (SAMPLE_BITS + 7) / 8;
   localparam int RSP_BYTES     = (VALUE_BITS + 7) / 8;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   last;
   } item_type;
endpackage

// ===== src/tmf_queue.sv =====
// Front queue: accepts requests and holds them for the back end.
module tmf_queue import tmf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type head
);
   item_type    entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        do_push, do_pop;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

// ===== src/tmf_core.sv =====
// Back end: sorted sample store, range sum sweep, serial divider, result register.
module tmf_core import tmf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [LIMIT_BITS-1:0]  mean_limit,
   input  logic                   item_valid,
   input  item_type               item,
   output logic                   item_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_BITS-1:0]  rsp_value,
   output logic                   rsp_median,
   output logic                   rsp_overflow
);
   typedef enum logic [1:0] {IDLE, SUM, DIV, DONE} state_type;

   state_type                state_ff;
   logic [SAMPLE_BITS-1:0]   store_ff [MAX_SAMPLES];
   logic [SAMPLE_BITS-1:0]   store_in [MAX_SAMPLES];
   logic [MAX_SAMPLES-1:0]   gt;
   logic [COUNT_BITS-1:0]    count_ff;
   logic                     ovf_ff;
   logic [COUNT_BITS-1:0]    idx_ff, hi_ff;
   logic [COUNT_BITS-1:0]    div_ff;
   logic                     median_ff;
   logic [SUM_BITS-1:0]      sum_ff;
   logic [DVD_BITS-1:0]      dvd_ff;
   logic [COUNT_BITS:0]      rem_ff;
   logic [STEP_BITS-1:0]     step_ff;
   logic                     rsp_valid_ff;
   logic [VALUE_BITS-1:0]    rsp_value_ff;
   logic                     rsp_median_ff, rsp_overflow_ff;

   logic                     room;
   logic [COUNT_BITS-1:0]    n, half, quarter, lo, hi, k;
   logic                     use_median;
   logic [COUNT_BITS+1:0]    trial;
   logic [COUNT_BITS:0]      rem_next;
   logic                     out_free;

   assign room     = (count_ff < COUNT_BITS'(MAX_SAMPLES));
   assign item_pop = (state_ff == IDLE) && item_valid;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // sorted insertion: every cell at or past the slot shifts up one
   always_comb begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
         gt[i] = (COUNT_BITS'(i) >= count_ff) || (store_ff[i] > item.sample);
      end
      store_in[0] = gt[0] ? item.sample : store_ff[0];
      for (int i = 1; i < MAX_SAMPLES; i++) begin
         if (!gt[i]) store_in[i] = store_ff[i];
         else if (!gt[i-1]) store_in[i] = item.sample;
         else store_in[i] = store_ff[i-1];
      end
   end

   // summation range and divisor for the burst just closed
   always_comb begin
      n          = count_ff + COUNT_BITS'(room);
      half       = n >> 1;
      quarter    = n >> 2;
      use_median = ({{(LIMIT_BITS+1){1'b0}}, n} <= {{(COUNT_BITS+1){1'b0}}, mean_limit});
      if (use_median) begin
         hi = half;
         lo = n[0] ? half : half - COUNT_BITS'(1);
         k  = n[0] ? COUNT_BITS'(1) : COUNT_BITS'(2);
      end else begin
         lo = quarter;
         hi = n - quarter - COUNT_BITS'(1);
         k  = n - (quarter << 1);
      end
      trial    = {rem_ff, dvd_ff[DVD_BITS-1]};
      rem_next = (trial >= {2'b00, div_ff}) ?
                 (COUNT_BITS+1)'(trial - {2'b00, div_ff}) :
                 (COUNT_BITS+1)'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !((state_ff == DONE) && out_free))
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (item_valid) begin
                  if (room) count_ff <= count_ff + COUNT_BITS'(1);
                  else ovf_ff <= 1'b1;
                  if (item.last) begin
                     idx_ff    <= lo;
                     hi_ff     <= hi;
                     div_ff    <= k;
                     median_ff <= use_median;
                     sum_ff    <= '0;
                     state_ff  <= SUM;
                  end
               end
            end
            SUM: begin
               sum_ff <= sum_ff + SUM_BITS'(store_ff[idx_ff[INDEX_BITS-1:0]]);
               idx_ff <= idx_ff + COUNT_BITS'(1);
               if (idx_ff == hi_ff) begin
                  state_ff <= DIV;
                  step_ff  <= '0;
                  rem_ff   <= '0;
                  dvd_ff   <= {sum_ff + SUM_BITS'(store_ff[idx_ff[INDEX_BITS-1:0]]),
                               {FRACTION_BITS{1'b0}}};
               end
            end
            DIV: begin
               rem_ff  <= rem_next;
               dvd_ff  <= {dvd_ff[DVD_BITS-2:0], trial >= {2'b00, div_ff}};
               step_ff <= step_ff + STEP_BITS'(1);
               if (step_ff == STEP_BITS'(DVD_BITS - 1)) state_ff <= DONE;
            end
            DONE: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_value_ff    <= (dvd_ff > DVD_BITS'(VALUE_MAX)) ?
                                     VALUE_MAX : VALUE_BITS'(dvd_ff);
                  rsp_median_ff   <= median_ff;
                  rsp_overflow_ff <= ovf_ff;
                  count_ff        <= '0;
                  ovf_ff          <= 1'b0;
                  state_ff        <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == IDLE) && item_valid && room) begin
         for (int i = 0; i < MAX_SAMPLES; i++) store_ff[i] <= store_in[i];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_median   = rsp_median_ff;
   assign rsp_overflow = rsp_overflow_ff;
endmodule

// ===== src/trimmed_mean_median_filter_unit.sv =====
// Top level of the trimmed mean / median filter.
// Usage:
//  - req channel carries one distance sample per request (tdata[15:0]),
//    req_tlast closes the burst and makes one response.
//  - rsp channel returns one response per burst: tdata[19:0] is the value
//    with 4 fraction bits, tuser[0] = median path, tuser[1] = overflow.
//  - csr_we/csr_wdata write mean_limit (reset 4); write only while idle.
//  - Each sample is inserted into the sorted store as it is popped from
//    the front queue.
//  - A closing request then costs a sum sweep over the kept samples, a
//    serial divide and a result load. No samples are taken meanwhile;
//    the 2-entry queue absorbs up to two requests.
//  - Samples beyond 32 in a burst are dropped and flagged.
//  - reset (synchronous) empties queue and burst and drops any response.
//  - A stalled rsp holds its response; the back end waits only if a new
//    response is ready while the old one is still unclaimed.
module trimmed_mean_median_filter_unit import tmf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_BYTES*8-1:0]     req_tdata,   // sample
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_BYTES*8-1:0]     rsp_tdata,   // filtered_value, zero pad
   output logic [1:0]                 rsp_tuser,   // used_median, overflowed
   input  logic                       csr_we,
   input  logic [LIMIT_BITS-1:0]      csr_wdata
);
   logic [LIMIT_BITS-1:0] mean_limit_ff;
   item_type              req_item, head;
   logic                  full, not_empty, pop;
   logic [VALUE_BITS-1:0] value;
   logic                  median, overflow;

   always_ff @(posedge clock) begin
      if (reset) mean_limit_ff <= LIMIT_BITS'(4);
      else if (csr_we) mean_limit_ff <= csr_wdata;
   end

   assign req_item.sample = req_tdata[SAMPLE_BITS-1:0];
   assign req_item.last   = req_tlast;
   assign req_tready      = !full;

   tmf_queue u_queue (
      .clock(clock), .reset(reset),
      .push(req_tvalid), .push_item(req_item), .full(full),
      .pop(pop), .not_empty(not_empty), .head(head)
   );

   tmf_core u_core (
      .clock(clock), .reset(reset), .mean_limit(mean_limit_ff),
      .item_valid(not_empty), .item(head), .item_pop(pop),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_value(value), .rsp_median(median), .rsp_overflow(overflow)
   );

   assign rsp_tdata = {{(RSP_BYTES*8-VALUE_BITS){1'b0}}, value};
   assign rsp_tuser = {overflow, median};
endmodule

// ===== src/tmf_checker.sv =====
// Port-level checks on the filter, bound to the top level.
`include "trimmed_mean_median_filter_unit_assert.svh"
module tmf_checker import tmf_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_BYTES*8-1:0] rsp_tdata,
   input logic [1:0]             rsp_tuser
);
   `TMF_ASSERT_NEXT(rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `TMF_ASSERT_NEXT(rsp_data_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser))
   `TMF_ASSERT_NOW(rsp_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[RSP_BYTES*8-1:VALUE_BITS] == '0)
endmodule

bind trimmed_mean_median_filter_unit tmf_checker u_tmf_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);

// ===== bench/trimmed_mean_median_filter_unit_test.sv =====
// Self-checking bench for the trimmed mean / median filter top level.
module trimmed_mean_median_filter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tmf_pkg::*;

   typedef struct {
      logic [VALUE_BITS-1:0] value;
      logic                  median;
      logic                  ovf;
   } filter_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_BYTES*8-1:0] req_tdata;   // sample
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_BYTES*8-1:0] rsp_tdata;   // filtered_value, zero pad
   logic [1:0]             rsp_tuser;   // used_median, overflowed
   logic                   csr_we;
   logic [LIMIT_BITS-1:0]  csr_wdata;

   trimmed_mean_median_filter_unit dut (.*);

   // Request queue fed by the stimulus process, drained by the driver.
   item_type          pending_reqs[$];
   filter_result_type expected_results[$];
   int                fail_count = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                idle_cycles = 0;
   bit                req_taken = 0;
   localparam int WATCHDOG_LIMIT = 20000;

   // Predictor state: sorted burst store, count, overflow, limit.
   logic [SAMPLE_BITS-1:0] burst_store[MAX_SAMPLES];
   int                     burst_count = 0;
   bit                     burst_ovf = 0;
   logic [LIMIT_BITS-1:0]  limit_shadow = 8'd4;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Insert one accepted sample; a closing sample yields one expectation.
   task automatic predict_request(item_type it);
      int pos;
      int trim;
      int kept;
      logic [63:0] sum;
      logic [63:0] val;
      filter_result_type r;
      if (burst_count < MAX_SAMPLES) begin
         pos = burst_count;
         while (pos > 0 && burst_store[pos-1] > it.sample) begin
            burst_store[pos] = burst_store[pos-1];
            pos--;
         end
         burst_store[pos] = it.sample;
         burst_count++;
      end else begin
         burst_ovf = 1;
      end
      if (!it.last) return;
      if (burst_count <= limit_shadow) begin
         r.median = 1;
         if (burst_count % 2)
            val = 64'(burst_store[burst_count/2]) << FRACTION_BITS;
         else
            val = ((64'(burst_store[burst_count/2-1]) + burst_store[burst_count/2])
                   << FRACTION_BITS) >> 1;
      end else begin
         r.median = 0;
         trim = burst_count / 4;
         kept = burst_count - 2*trim;
         sum = 0;
         for (int i = trim; i < burst_count - trim; i++) sum += burst_store[i];
         val = (sum << FRACTION_BITS) / kept;
      end
      if (val > VALUE_MAX) val = VALUE_MAX;
      r.value = val[VALUE_BITS-1:0];
      r.ovf = burst_ovf;
      expected_results.push_back(r);
      burst_count = 0;
      burst_ovf = 0;
   endtask

   // Driver: changes on the falling edge; acceptance seen at the rising edge.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (req_tvalid && !req_taken) begin
         // hold the request until accepted
      end else if (pending_reqs.size() > 0 &&
                   $urandom_range(99, 0) >= send_idle_pct) begin
         req_tvalid <= 1;
         req_tdata  <= pending_reqs[0].sample;
         req_tlast  <= pending_reqs[0].last;
         void'(pending_reqs.pop_front());
      end else begin
         req_tvalid <= 0;
      end
      rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // Monitor: predicts on accepted requests, checks accepted responses.
   always @(posedge clock) begin
      filter_result_type exp_r;
      bit                moved;
      moved = 0;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_request('{sample: req_tdata, last: req_tlast});
            moved = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response value=%h user=%b",
                        $realtime, rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_tdata[VALUE_BITS-1:0] !== exp_r.value ||
                   rsp_tdata[RSP_BYTES*8-1:VALUE_BITS] !== '0 ||
                   rsp_tuser[0] !== exp_r.median || rsp_tuser[1] !== exp_r.ovf) begin
                  $display({"%0t: mismatch expected value=%h med=%b ovf=%b",
                            " actual value=%h med=%b ovf=%b"},
                           $realtime, exp_r.value, exp_r.median, exp_r.ovf,
                           rsp_tdata, rsp_tuser[0], rsp_tuser[1]);
                  fail_count++;
               end
            end
         end
         if (moved) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Random sample: mostly full-range, some small-range and extremes.
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(3, 0))
         0: return SAMPLE_BITS'(16'hFFFF - SAMPLE_BITS'($urandom_range(3, 0)));
         1: return SAMPLE_BITS'($urandom_range(15, 0));
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   task automatic queue_burst(int len);
      for (int i = 0; i < len; i++)
         pending_reqs.push_back('{sample: pick_sample(), last: (i == len-1)});
   endtask

   // Wait until all queued requests went out and every response arrived.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_BITS-1:0] v);
      @(negedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      limit_shadow = v;
   endtask

   initial begin
      int sent;
      int len;
      logic [LIMIT_BITS-1:0] limits[5] = '{8'd0, 8'd255, 8'd7, 8'd16, 8'd32};
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tlast = 0;
      rsp_tready = 0;
      csr_we = 0;
      csr_wdata = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: reset limit, single sample extremes, median even/odd.
      pending_reqs.push_back('{sample: 16'hFFFF, last: 1});
      pending_reqs.push_back('{sample: 16'h0000, last: 1});
      pending_reqs.push_back('{sample: 16'hFFFF, last: 0});
      pending_reqs.push_back('{sample: 16'hFFFE, last: 1});
      pending_reqs.push_back('{sample: 16'h0003, last: 0});
      pending_reqs.push_back('{sample: 16'h0001, last: 0});
      pending_reqs.push_back('{sample: 16'h0002, last: 1});
      // Trimmed mean on five samples incl. equal values.
      for (int i = 0; i < 5; i++)
         pending_reqs.push_back('{sample: (i < 3) ? 16'h5555 : 16'hAAAA, last: (i == 4)});
      drain();
      // Store full: 34 samples, last two dropped; the last one still closes the burst.
      for (int i = 0; i < 34; i++)
         pending_reqs.push_back('{sample: 16'hFFFF - i, last: (i == 33)});
      drain();

      // Random phases across limits and idling profiles.
      sent = 0;
      for (int ph = 0; ph < 15; ph++) begin
         write_limit((ph < 5) ? limits[ph] : 8'($urandom()));
         send_idle_pct = (ph < 5) ? 8 : (ph < 10) ? 68 : 0;
         recv_idle_pct = (ph < 5) ? 68 : (ph < 10) ? 8 : 0;
         for (int b = 0; b < 10; b++) begin
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(36, 28)
                                             : $urandom_range(8, 1);
            queue_burst(len);
            sent += len;
         end
         drain();
      end
      while (sent < 1150) begin
         len = $urandom_range(10, 1);
         queue_burst(len);
         sent = sent + len;
      end
      drain();

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
